@@ rtl/core/hed_pkg.sv @@
// ============================================================================
// hed_pkg
// shared types and constants for the heading error and distance pipeline
// ============================================================================
package hed_pkg;

    localparam int POS_W        = 32;
    localparam int ANG_W        = 15;
    localparam int DIST_W       = 33;
    localparam int DELTA_W      = 33;
    localparam int MAG_W        = 33;
    localparam int HI_W         = 17;
    localparam int LO_W         = 16;
    localparam int SUMSQ_W      = 66;
    localparam int REM_W        = 37;
    localparam int MAG_SHIFT    = 24;
    localparam int CX_W         = 59;
    localparam int Z_W          = 32;
    localparam int ZC_W         = 29;
    localparam int ZQ_W         = 30;
    localparam int TURN_W       = 17;
    localparam int FRONT_STAGES = 5;
    localparam int SQRT_STAGES  = 33;
    localparam int PIPE_DEPTH   = FRONT_STAGES + SQRT_STAGES + 1;
    localparam int CORDIC_START = 3;
    localparam int ATAN_ENTRIES = 32;
    localparam int ROUND_SHIFT  = 16;

    typedef logic signed [POS_W-1:0]  pos_t;
    typedef logic signed [ANG_W-1:0]  ang_t;
    typedef logic        [DIST_W-1:0] dist_t;
    typedef logic        [MAG_W-1:0]  mag_t;
    typedef logic      [SUMSQ_W-1:0]  sumsq_t;
    typedef logic signed [TURN_W-1:0] turn_t;
    typedef logic [PIPE_DEPTH:1]      stage_en_t;

    typedef struct packed {
        logic dx_neg;
        logic dy_neg;
        logic ax_zero;
        logic ay_zero;
    } quad_t;

    localparam logic [ZC_W-1:0] HALF_PI_A  = 29'd421657428;
    localparam logic [ZQ_W-1:0] PI_A       = 30'd843314857;
    localparam turn_t           PI_Q       = 17'sd12868;
    localparam turn_t           TWO_PI_Q   = 17'sd25736;
    localparam logic [15:0]     ROUND_HALF = 16'd32768;

    // atan(2^-i) in units of 2^-28 rad
    localparam logic [27:0] ATAN_TAB [ATAN_ENTRIES] = '{
        28'd210828714, 28'd124459457, 28'd65760959, 28'd33381290,
        28'd16755422,  28'd8385879,   28'd4193963,  28'd2097109,
        28'd1048571,   28'd524287,    28'd262144,   28'd131072,
        28'd65536,     28'd32768,     28'd16384,    28'd8192,
        28'd4096,      28'd2048,      28'd1024,     28'd512,
        28'd256,       28'd128,       28'd64,       28'd32,
        28'd16,        28'd8,         28'd4,        28'd2,
        28'd1,         28'd0,         28'd0,        28'd0
    };

endpackage

@@ rtl/core/hed_req_if.sv @@
// ============================================================================
// hed_req_if
// request channel: robot pose and goal position
// ============================================================================
interface hed_req_if;
    import hed_pkg::*;

    logic valid;
    logic ready;
    pos_t robot_x;
    pos_t robot_y;
    ang_t robot_yaw;
    pos_t goal_x;
    pos_t goal_y;

    modport source (
        output valid, robot_x, robot_y, robot_yaw, goal_x, goal_y,
        input  ready
    );

    modport sink (
        input  valid, robot_x, robot_y, robot_yaw, goal_x, goal_y,
        output ready
    );
endinterface

@@ rtl/core/hed_rsp_if.sv @@
// ============================================================================
// hed_rsp_if
// response channel: distance to goal and turn angle
// ============================================================================
interface hed_rsp_if;
    import hed_pkg::*;

    logic  valid;
    logic  ready;
    dist_t distance;
    ang_t  turn_angle;

    modport source (
        output valid, distance, turn_angle,
        input  ready
    );

    modport sink (
        input  valid, distance, turn_angle,
        output ready
    );
endinterface

@@ rtl/core/heading_error_and_distance.sv @@
// ============================================================================
// heading_error_and_distance
// distance to a goal and signed turn toward it from a robot pose
// ============================================================================
// A request on req carries robot_x, robot_y, goal_x, goal_y (signed Q16.16)
// and robot_yaw (signed Q3.12 rad). Each request yields one response on rsp:
// distance (unsigned Q17.16, nearest) and turn_angle (signed Q3.12 rad,
// positive is a left turn, wrapped once into minus pi to pi).
// An accepted request passes the five front stages, the 33-stage square root
// and a rounding stage before its response is valid; the CORDIC_STAGES
// vectoring stages run alongside them.
// Throughput is one request per cycle unless rsp.ready stalls. Every stage
// has a valid bit and loads whenever it is empty or its successor moves, so
// a stalled rsp.ready only holds the full stages and req.ready stays high
// while bubbles remain. Responses come out in request order. Reset (rst_n
// low, asynchronous) empties the pipeline; payload registers are not cleared.
// ============================================================================
module heading_error_and_distance #(
    parameter int CORDIC_STAGES = 24
) (
    input  logic      clk,
    input  logic      rst_n,
    hed_req_if.sink   req,
    hed_rsp_if.source rsp
);
    import hed_pkg::*;

    stage_en_t ld;
    mag_t      ax;
    mag_t      ay;
    quad_t     quad;
    ang_t      yaw;
    sumsq_t    sumsq;
    dist_t     distance;
    ang_t      turn_angle;

    hed_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .ld        (ld)
    );

    hed_front u_front (
        .clk       (clk),
        .ld        (ld),
        .robot_x   (req.robot_x),
        .robot_y   (req.robot_y),
        .robot_yaw (req.robot_yaw),
        .goal_x    (req.goal_x),
        .goal_y    (req.goal_y),
        .ax        (ax),
        .ay        (ay),
        .quad      (quad),
        .yaw       (yaw),
        .sumsq     (sumsq)
    );

    hed_sqrt u_sqrt (
        .clk      (clk),
        .ld       (ld),
        .sumsq    (sumsq),
        .distance (distance)
    );

    hed_angle #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_angle (
        .clk        (clk),
        .ld         (ld),
        .ax         (ax),
        .ay         (ay),
        .quad       (quad),
        .yaw        (yaw),
        .turn_angle (turn_angle)
    );

    assign rsp.distance   = distance;
    assign rsp.turn_angle = turn_angle;
endmodule

@@ rtl/core/hed_ctrl.sv @@
// ============================================================================
// hed_ctrl
// per-stage valid bits and load enables, bubbles collapse on stall
// ============================================================================
module hed_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output hed_pkg::stage_en_t ld
);
    import hed_pkg::*;

    stage_en_t valid_reg;
    stage_en_t valid_next;
    stage_en_t ld_next;

    always_comb
    begin
        ld_next[PIPE_DEPTH] = !valid_reg[PIPE_DEPTH] || out_ready;
        for (int k = PIPE_DEPTH - 1; k >= 1; k--)
        begin
            ld_next[k] = !valid_reg[k] || ld_next[k+1];
        end
        valid_next[1] = ld_next[1] ? in_valid : valid_reg[1];
        for (int k = 2; k <= PIPE_DEPTH; k++)
        begin
            valid_next[k] = ld_next[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign ld        = ld_next;
    assign in_ready  = ld_next[1];
    assign out_valid = valid_reg[PIPE_DEPTH];
endmodule

@@ rtl/core/hed_front.sv @@
// ============================================================================
// hed_front
// deltas, magnitudes, split squares and the sum of squares (stages 1 to 5)
// ============================================================================
module hed_front (
    input  logic               clk,
    input  hed_pkg::stage_en_t ld,
    input  hed_pkg::pos_t      robot_x,
    input  hed_pkg::pos_t      robot_y,
    input  hed_pkg::ang_t      robot_yaw,
    input  hed_pkg::pos_t      goal_x,
    input  hed_pkg::pos_t      goal_y,
    output hed_pkg::mag_t      ax,
    output hed_pkg::mag_t      ay,
    output hed_pkg::quad_t     quad,
    output hed_pkg::ang_t      yaw,
    output hed_pkg::sumsq_t    sumsq
);
    import hed_pkg::*;

    typedef logic signed [DELTA_W-1:0] delta_t;

    delta_t dx_reg;
    delta_t dy_reg;
    ang_t   yaw1_reg;
    ang_t   yaw2_reg;
    mag_t   ax_reg;
    mag_t   ay_reg;
    quad_t  quad_reg;

    logic [2*HI_W-1:0]    xhh_reg;
    logic [2*HI_W-1:0]    yhh_reg;
    logic [HI_W+LO_W-1:0] xhl_reg;
    logic [HI_W+LO_W-1:0] yhl_reg;
    logic [2*LO_W-1:0]    xll_reg;
    logic [2*LO_W-1:0]    yll_reg;

    sumsq_t sqx_reg;
    sumsq_t sqy_reg;
    sumsq_t sumsq_reg;

    delta_t dx_next;
    delta_t dy_next;
    mag_t   ax_next;
    mag_t   ay_next;
    quad_t  quad_next;
    sumsq_t sqx_next;
    sumsq_t sqy_next;

    always_comb
    begin
        dx_next = DELTA_W'(goal_x) - DELTA_W'(robot_x);
        dy_next = DELTA_W'(goal_y) - DELTA_W'(robot_y);

        ax_next = dx_reg[DELTA_W-1] ? mag_t'(-dx_reg) : mag_t'(dx_reg);
        ay_next = dy_reg[DELTA_W-1] ? mag_t'(-dy_reg) : mag_t'(dy_reg);
        quad_next.dx_neg  = dx_reg[DELTA_W-1];
        quad_next.dy_neg  = dy_reg[DELTA_W-1];
        quad_next.ax_zero = (dx_reg == '0);
        quad_next.ay_zero = (dy_reg == '0);

        // a^2 = hh * 2^32 + 2 * hl * 2^16 + ll
        sqx_next = {xhh_reg, {(2*LO_W){1'b0}}}
                 + (SUMSQ_W'(xhl_reg) << (LO_W + 1))
                 + SUMSQ_W'(xll_reg);
        sqy_next = {yhh_reg, {(2*LO_W){1'b0}}}
                 + (SUMSQ_W'(yhl_reg) << (LO_W + 1))
                 + SUMSQ_W'(yll_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ld[1])
        begin
            dx_reg   <= dx_next;
            dy_reg   <= dy_next;
            yaw1_reg <= robot_yaw;
        end
        if (ld[2])
        begin
            ax_reg   <= ax_next;
            ay_reg   <= ay_next;
            quad_reg <= quad_next;
            yaw2_reg <= yaw1_reg;
        end
        if (ld[3])
        begin
            xhh_reg <= ax_reg[MAG_W-1:LO_W] * ax_reg[MAG_W-1:LO_W];
            xhl_reg <= ax_reg[MAG_W-1:LO_W] * ax_reg[LO_W-1:0];
            xll_reg <= ax_reg[LO_W-1:0] * ax_reg[LO_W-1:0];
            yhh_reg <= ay_reg[MAG_W-1:LO_W] * ay_reg[MAG_W-1:LO_W];
            yhl_reg <= ay_reg[MAG_W-1:LO_W] * ay_reg[LO_W-1:0];
            yll_reg <= ay_reg[LO_W-1:0] * ay_reg[LO_W-1:0];
        end
        if (ld[4])
        begin
            sqx_reg <= sqx_next;
            sqy_reg <= sqy_next;
        end
        if (ld[5])
        begin
            sumsq_reg <= sqx_reg + sqy_reg;
        end
    end

    assign ax    = ax_reg;
    assign ay    = ay_reg;
    assign quad  = quad_reg;
    assign yaw   = yaw2_reg;
    assign sumsq = sumsq_reg;
endmodule

@@ rtl/core/hed_sqrt.sv @@
// ============================================================================
// hed_sqrt
// pipelined restoring square root, one result bit per stage, then rounding
// ============================================================================
module hed_sqrt (
    input  logic               clk,
    input  hed_pkg::stage_en_t ld,
    input  hed_pkg::sumsq_t    sumsq,
    output hed_pkg::dist_t     distance
);
    import hed_pkg::*;

    typedef logic [REM_W-1:0] rem_t;

    dist_t  root_reg  [SQRT_STAGES];
    rem_t   rem_reg   [SQRT_STAGES];
    sumsq_t rad_reg   [SQRT_STAGES];
    dist_t  root_next [SQRT_STAGES];
    rem_t   rem_next  [SQRT_STAGES];
    sumsq_t rad_next  [SQRT_STAGES];
    dist_t  dist_reg;
    dist_t  dist_next;

    always_comb
    begin
        dist_t        root_in;
        rem_t         rem_in;
        sumsq_t       rad_in;
        rem_t         rem4;
        rem_t         trial;
        logic [REM_W:0] diff;

        for (int s = 0; s < SQRT_STAGES; s++)
        begin
            if (s == 0)
            begin
                root_in = '0;
                rem_in  = '0;
                rad_in  = sumsq;
            end
            else
            begin
                root_in = root_reg[s-1];
                rem_in  = rem_reg[s-1];
                rad_in  = rad_reg[s-1];
            end
            rem4  = {rem_in[REM_W-3:0], rad_in[SUMSQ_W-1 -: 2]};
            trial = REM_W'({root_in, 2'b01});
            diff  = {1'b0, rem4} - {1'b0, trial};
            root_next[s] = {root_in[DIST_W-2:0], !diff[REM_W]};
            rem_next[s]  = diff[REM_W] ? rem4 : diff[REM_W-1:0];
            rad_next[s]  = rad_in << 2;
        end

        // round to nearest: bump when remainder exceeds the root
        dist_next = root_reg[SQRT_STAGES-1]
                  + DIST_W'(rem_reg[SQRT_STAGES-1] > REM_W'(root_reg[SQRT_STAGES-1]));
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < SQRT_STAGES; s++)
        begin
            if (ld[FRONT_STAGES + 1 + s])
            begin
                root_reg[s] <= root_next[s];
                rem_reg[s]  <= rem_next[s];
                rad_reg[s]  <= rad_next[s];
            end
        end
        if (ld[PIPE_DEPTH])
        begin
            dist_reg <= dist_next;
        end
    end

    assign distance = dist_reg;
endmodule

@@ rtl/core/hed_angle.sv @@
// ============================================================================
// hed_angle
// pipelined cordic vectoring, quadrant mapping, rounding and turn wrap
// ============================================================================
module hed_angle #(
    parameter int CORDIC_STAGES = 24
) (
    input  logic               clk,
    input  hed_pkg::stage_en_t ld,
    input  hed_pkg::mag_t      ax,
    input  hed_pkg::mag_t      ay,
    input  hed_pkg::quad_t     quad,
    input  hed_pkg::ang_t      yaw,
    output hed_pkg::ang_t      turn_angle
);
    import hed_pkg::*;

    localparam int POST_END = CORDIC_START + CORDIC_STAGES + 3;
    localparam int DLY      = PIPE_DEPTH - POST_END;

    typedef logic [CX_W-1:0]       cx_t;
    typedef logic signed [Z_W-1:0] z_t;

    // y is held as sign flag plus magnitude
    cx_t   cx_reg    [CORDIC_STAGES];
    cx_t   cm_reg    [CORDIC_STAGES];
    logic  cpos_reg  [CORDIC_STAGES];
    z_t    cz_reg    [CORDIC_STAGES];
    quad_t cq_reg    [CORDIC_STAGES];
    ang_t  cyaw_reg  [CORDIC_STAGES];
    cx_t   cx_next   [CORDIC_STAGES];
    cx_t   cm_next   [CORDIC_STAGES];
    logic  cpos_next [CORDIC_STAGES];
    z_t    cz_next   [CORDIC_STAGES];
    quad_t cq_next   [CORDIC_STAGES];
    ang_t  cyaw_next [CORDIC_STAGES];

    logic [ZC_W-1:0] zc_reg;
    quad_t           q1_reg;
    ang_t            yaw1_reg;
    logic [ZQ_W-1:0] z2_reg;
    logic            neg_reg;
    ang_t            yaw2_reg;
    turn_t           bearing_reg;
    ang_t            yaw3_reg;
    ang_t            turn_dly_reg [DLY+1];

    logic [ZC_W-1:0] zc_next;
    logic [ZQ_W-1:0] z2_next;
    logic            neg_next;
    turn_t           bearing_next;
    ang_t            turn_next;

    always_comb
    begin
        cx_t   x_in;
        cx_t   m_in;
        cx_t   xs;
        cx_t   ms;
        logic  pos_in;
        z_t    z_in;
        quad_t q_in;
        ang_t  yaw_in;
        logic  gt;
        logic  lt;

        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            if (i == 0)
            begin
                x_in   = CX_W'(ax) << MAG_SHIFT;
                m_in   = CX_W'(ay) << MAG_SHIFT;
                pos_in = (ay != '0);
                z_in   = '0;
                q_in   = quad;
                yaw_in = yaw;
            end
            else
            begin
                x_in   = cx_reg[i-1];
                m_in   = cm_reg[i-1];
                pos_in = cpos_reg[i-1];
                z_in   = cz_reg[i-1];
                q_in   = cq_reg[i-1];
                yaw_in = cyaw_reg[i-1];
            end
            xs = x_in >> i;
            ms = m_in >> i;
            gt = (m_in > xs);
            lt = (m_in < xs);
            cx_next[i]   = x_in + ms;
            cm_next[i]   = gt ? (m_in - xs) : (xs - m_in);
            cpos_next[i] = (pos_in && gt) || (!pos_in && lt);
            cz_next[i]   = pos_in ? (z_in + z_t'(ATAN_TAB[i])) : (z_in - z_t'(ATAN_TAB[i]));
            cq_next[i]   = q_in;
            cyaw_next[i] = yaw_in;
        end
    end

    always_comb
    begin
        z_t                zf;
        logic [ZQ_W:0]     rsum;
        logic [ZQ_W-ROUND_SHIFT:0] mag;
        turn_t             t;

        // clamp to first quadrant, axis cases exact
        zf = cz_reg[CORDIC_STAGES-1];
        if (cq_reg[CORDIC_STAGES-1].ax_zero)
        begin
            zc_next = HALF_PI_A;
        end
        else if (cq_reg[CORDIC_STAGES-1].ay_zero || zf[Z_W-1])
        begin
            zc_next = '0;
        end
        else if (zf > z_t'(HALF_PI_A))
        begin
            zc_next = HALF_PI_A;
        end
        else
        begin
            zc_next = zf[ZC_W-1:0];
        end

        // quadrant; goal on robot gives minus half pi
        if (q1_reg.ax_zero && q1_reg.ay_zero)
        begin
            z2_next  = ZQ_W'(HALF_PI_A);
            neg_next = 1'b1;
        end
        else
        begin
            z2_next  = q1_reg.dx_neg ? (PI_A - ZQ_W'(zc_reg)) : ZQ_W'(zc_reg);
            neg_next = q1_reg.dy_neg;
        end

        rsum = (ZQ_W+1)'(z2_reg) + (ZQ_W+1)'(ROUND_HALF);
        mag  = rsum[ZQ_W:ROUND_SHIFT];
        bearing_next = neg_reg ? -turn_t'(mag) : turn_t'(mag);

        t = bearing_reg - turn_t'(yaw3_reg);
        if (t > PI_Q)
        begin
            t = t - TWO_PI_Q;
        end
        else if (t < -PI_Q)
        begin
            t = t + TWO_PI_Q;
        end
        turn_next = t[ANG_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            if (ld[CORDIC_START + i])
            begin
                cx_reg[i]   <= cx_next[i];
                cm_reg[i]   <= cm_next[i];
                cpos_reg[i] <= cpos_next[i];
                cz_reg[i]   <= cz_next[i];
                cq_reg[i]   <= cq_next[i];
                cyaw_reg[i] <= cyaw_next[i];
            end
        end
        if (ld[POST_END - 3])
        begin
            zc_reg   <= zc_next;
            q1_reg   <= cq_reg[CORDIC_STAGES-1];
            yaw1_reg <= cyaw_reg[CORDIC_STAGES-1];
        end
        if (ld[POST_END - 2])
        begin
            z2_reg   <= z2_next;
            neg_reg  <= neg_next;
            yaw2_reg <= yaw1_reg;
        end
        if (ld[POST_END - 1])
        begin
            bearing_reg <= bearing_next;
            yaw3_reg    <= yaw2_reg;
        end
        if (ld[POST_END])
        begin
            turn_dly_reg[0] <= turn_next;
        end
        for (int d = 1; d <= DLY; d++)
        begin
            if (ld[POST_END + d])
            begin
                turn_dly_reg[d] <= turn_dly_reg[d-1];
            end
        end
    end

    assign turn_angle = turn_dly_reg[DLY];
endmodule

@@ test/heading_error_and_distance_check.sv @@
// ============================================================================
// heading_error_and_distance_check
// watches the request and response channels and checks every response
// ----------------------------------------------------------------------------
// Each accepted request is run through a bit-level model of the block:
// rounded integer square root for the distance, a vectoring CORDIC with the
// same stage count for the bearing, quadrant mapping, rounding to Q3.12 and
// a single wrap of the turn into minus pi to pi. Responses are compared in
// order. Distance must match exactly. The turn may differ by up to two LSB,
// measured around the circle. Counts go back to the testbench top.
// ============================================================================
module heading_error_and_distance_check #(
    parameter int CORDIC_STAGES = 24
) (
    input  logic clk,
    input  logic rst_n,
    hed_req_if   req,
    hed_rsp_if   rsp,
    output int   fail_count,
    output int   outstanding,
    output int   checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import hed_pkg::*;

    localparam longint HALF_PI_FIX = 64'd421657428;
    localparam longint PI_FIX      = 64'd843314857;
    localparam longint PI_Q4       = 64'd12868;
    localparam longint TWO_PI_Q4   = 64'd25736;
    localparam int     ANGLE_TOL   = 2;

    // atan(2^-i) in units of 2^-28 rad
    localparam longint ATAN_STEP [32] = '{
        210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
        4193963, 2097109, 1048571, 524287, 262144, 131072, 65536, 32768,
        16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2,
        1, 0, 0, 0
    };

    typedef struct packed {
        dist_t distance;
        ang_t  turn_angle;
    } steer_t;

    steer_t due_steers [$];
    int     errors;
    int     matched;

    function automatic steer_t steer_to_goal(pos_t rx, pos_t ry, ang_t yaw,
                                             pos_t gx, pos_t gy);
        longint      dx, dy, ax, ay, x, y, z, xs, ys, mag, turn;
        logic [67:0] ux, uy, total, root, trial;
        steer_t      res;
        dx = longint'(gx) - longint'(rx);
        dy = longint'(gy) - longint'(ry);
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;

        // bearing
        if (dx == 0 && dy == 0)
            z = -HALF_PI_FIX;
        else
        begin
            if (ax == 0)
                z = HALF_PI_FIX;
            else if (ay == 0)
                z = 0;
            else
            begin
                x = ax <<< MAG_SHIFT;
                y = ay <<< MAG_SHIFT;
                z = 0;
                for (int i = 0; i < CORDIC_STAGES && i < 32; i++)
                begin
                    xs = (x < 0) ? -((-x) >>> i) : (x >>> i);
                    ys = (y < 0) ? -((-y) >>> i) : (y >>> i);
                    if (y > 0)
                    begin
                        x = x + ys;
                        y = y - xs;
                        z = z + ATAN_STEP[i];
                    end
                    else
                    begin
                        x = x - ys;
                        y = y + xs;
                        z = z - ATAN_STEP[i];
                    end
                end
                if (z < 0)
                    z = 0;
                if (z > HALF_PI_FIX)
                    z = HALF_PI_FIX;
            end
            if (dx < 0)
                z = PI_FIX - z;
            if (dy < 0)
                z = -z;
        end

        // round to q3.12, ties away from zero, then one wrap
        mag = (z < 0) ? -z : z;
        mag = (mag + 32768) >>> 16;
        turn = ((z < 0) ? -mag : mag) - longint'(yaw);
        if (turn > PI_Q4)
            turn = turn - TWO_PI_Q4;
        else if (turn < -PI_Q4)
            turn = turn + TWO_PI_Q4;

        // rounded square root
        ux = 68'(ax);
        uy = 68'(ay);
        total = ux * ux + uy * uy;
        root = '0;
        for (int b = 33; b >= 0; b--)
        begin
            trial = root | (68'd1 << b);
            if (trial * trial <= total)
                root = trial;
        end
        if (total > root * root + root)
            root = root + 68'd1;

        res.distance   = root[DIST_W-1:0];
        res.turn_angle = ang_t'(turn);
        return res;
    endfunction

    always @(posedge clk)
    begin : watch
        steer_t want;
        int     gap;
        if (!rst_n)
        begin
            due_steers.delete();
            errors  = 0;
            matched = 0;
        end
        else
        begin
            if (req.valid && req.ready)
                due_steers.push_back(steer_to_goal(req.robot_x, req.robot_y,
                                                   req.robot_yaw, req.goal_x,
                                                   req.goal_y));
            if (rsp.valid && rsp.ready)
            begin
                if (due_steers.size() == 0)
                begin
                    errors++;
                    $error("unrequested response: distance %0d turn_angle %0d",
                           rsp.distance, rsp.turn_angle);
                end
                else
                begin
                    want = due_steers.pop_front();
                    matched++;
                    if (rsp.distance !== want.distance)
                    begin
                        errors++;
                        $error("distance: expected %0d, got %0d",
                               want.distance, rsp.distance);
                    end
                    gap = int'(rsp.turn_angle) - int'(want.turn_angle);
                    if (gap > int'(PI_Q4))
                        gap = gap - int'(TWO_PI_Q4);
                    else if (gap < -int'(PI_Q4))
                        gap = gap + int'(TWO_PI_Q4);
                    if ($isunknown(rsp.turn_angle) || gap > ANGLE_TOL
                        || gap < -ANGLE_TOL)
                    begin
                        errors++;
                        $error("turn_angle: expected %0d, got %0d",
                               want.turn_angle, rsp.turn_angle);
                    end
                end
            end
        end
        fail_count  <= errors;
        outstanding <= due_steers.size();
        checked     <= matched;
    end

endmodule

@@ test/heading_error_and_distance_tb.sv @@
// ============================================================================
// heading_error_and_distance_tb
// stimulus and verdict for the heading error and distance pipeline
// ----------------------------------------------------------------------------
// Sends directed requests (goal on the robot, each axis, turns of exactly
// plus and minus pi, headings outside minus pi to pi, full-scale distances)
// and then random poses, mostly with the goal near the robot. Requests go
// out in bursts with random gaps; the response side stalls in changing
// patterns. A checker beside the block predicts and compares each response.
// ============================================================================
module heading_error_and_distance_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hed_pkg::*;

    localparam int   CORDIC_STAGES = 24;
    localparam int   ITEMS         = 500;
    localparam int   LIMIT         = 200000;
    localparam int   DRAIN         = 60;
    localparam pos_t POS_MIN       = 32'sh8000_0000;
    localparam pos_t POS_MAX       = 32'sh7fff_ffff;
    localparam pos_t ONE_M         = 32'sh0001_0000;
    localparam ang_t YAW_PI        = 15'sd12868;
    localparam ang_t YAW_MIN       = 15'sh4000;
    localparam ang_t YAW_MAX       = 15'sh3fff;

    typedef enum int {ALWAYS_READY, HALF_READY, RARE_READY, PERIODIC_READY} stall_mode_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    int   cycle_count = 0;
    int   fail_count;
    int   outstanding;
    int   checked;
    int   sent = 0;
    int   directed = 0;
    int   on_robot = 0;
    int   burst_left = 0;

    hed_req_if req ();
    hed_rsp_if rsp ();

    heading_error_and_distance #(
        .CORDIC_STAGES(CORDIC_STAGES)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req),
        .rsp  (rsp)
    );

    heading_error_and_distance_check #(
        .CORDIC_STAGES(CORDIC_STAGES)
    ) steer_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .fail_count (fail_count),
        .outstanding(outstanding),
        .checked    (checked)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic send_request(input pos_t rx, input pos_t ry, input ang_t yaw,
                                input pos_t gx, input pos_t gy);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                req.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        req.valid     <= 1'b1;
        req.robot_x   <= rx;
        req.robot_y   <= ry;
        req.robot_yaw <= yaw;
        req.goal_x    <= gx;
        req.goal_y    <= gy;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        sent++;
        if (rx == gx && ry == gy)
            on_robot++;
    endtask

    function automatic pos_t offset_from(pos_t base, int span);
        int off;
        off = int'($urandom_range(0, 1 << span));
        if ($urandom_range(0, 1) == 1)
            off = -off;
        return base + off;
    endfunction

    // response stalls
    initial
    begin : rsp_stall
        stall_mode_t mode;
        int          left;
        mode = ALWAYS_READY;
        left = 0;
        rsp.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (left == 0)
            begin
                mode = stall_mode_t'($urandom_range(0, 3));
                left = $urandom_range(20, 120);
            end
            left--;
            case (mode)
                ALWAYS_READY:   rsp.ready <= 1'b1;
                HALF_READY:     rsp.ready <= ($urandom_range(0, 1) == 1);
                RARE_READY:     rsp.ready <= ($urandom_range(0, 3) == 0);
                PERIODIC_READY: rsp.ready <= (left % 5 != 0);
                default:        rsp.ready <= 1'b1;
            endcase
            @(posedge clk);
        end
    end

    initial
    begin : watchdog
        while (cycle_count < LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $error("timeout after %0d cycles", cycle_count);
        $display("heading_error_and_distance_tb NOT OK");
        $finish;
    end

    initial
    begin : stimulus
        pos_t rx, ry, gx, gy;
        ang_t yaw;
        int   kind;
        int   span;
        req.valid     <= 1'b0;
        req.robot_x   <= '0;
        req.robot_y   <= '0;
        req.robot_yaw <= '0;
        req.goal_x    <= '0;
        req.goal_y    <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // goal on robot
        send_request('0, '0, '0, '0, '0);
        send_request(ONE_M, -ONE_M, YAW_PI, ONE_M, -ONE_M);
        send_request(POS_MAX, POS_MIN, -YAW_PI, POS_MAX, POS_MIN);
        // axis bearings
        send_request('0, '0, '0, 32'sd1, '0);
        send_request('0, '0, '0, -32'sd1, '0);
        send_request('0, '0, -YAW_PI, -ONE_M, '0);
        send_request('0, '0, '0, '0, 5 * ONE_M);
        send_request(ONE_M, ONE_M, '0, ONE_M, -3 * ONE_M);
        // turns of exactly plus and minus pi
        send_request('0, '0, -YAW_PI, ONE_M, '0);
        send_request('0, '0, YAW_PI, ONE_M, '0);
        // heading outside minus pi to pi
        send_request('0, '0, YAW_MAX, -ONE_M, '0);
        send_request('0, '0, YAW_MIN, '0, -ONE_M);
        send_request('0, '0, YAW_MAX, '0, ONE_M);
        send_request('0, '0, YAW_MIN, ONE_M, ONE_M);
        // full-scale distances
        send_request(POS_MIN, POS_MIN, '0, POS_MAX, POS_MAX);
        send_request(POS_MAX, POS_MIN, 15'sd1, POS_MIN, POS_MAX);
        send_request(POS_MAX, POS_MAX, -15'sd1, POS_MIN, POS_MIN);
        send_request(POS_MIN, '0, '0, POS_MAX, '0);
        // diagonals and steep or shallow bearings
        send_request('0, '0, '0, 32'sd1, 32'sd1);
        send_request('0, '0, '0, -32'sd1, -32'sd1);
        send_request('0, '0, '0, POS_MAX, 32'sd1);
        send_request('0, '0, '0, -32'sd1, POS_MIN);
        send_request(-32'sd1, -32'sd1, YAW_PI, '0, '0);
        directed = sent;

        for (int n = 0; n < ITEMS; n++)
        begin
            rx   = $urandom;
            ry   = $urandom;
            yaw  = ang_t'(int'($urandom_range(0, 25736)) - 12868);
            kind = $urandom_range(0, 9);
            span = $urandom_range(0, 20);
            case (kind)
                0, 1:
                begin
                    gx  = $urandom;
                    gy  = $urandom;
                    yaw = ang_t'($urandom);
                end
                7:
                begin
                    gx = ($urandom_range(0, 1) == 1) ? rx : offset_from(rx, span);
                    gy = (gx == rx) ? offset_from(ry, span) : ry;
                end
                8:
                begin
                    gx = offset_from(rx, 0);
                    gy = offset_from(ry, 0);
                end
                9:
                begin
                    gx  = offset_from(rx, span);
                    gy  = offset_from(ry, span);
                    yaw = ($urandom_range(0, 1) == 1) ? YAW_PI : -YAW_PI;
                end
                default:
                begin
                    gx = offset_from(rx, span);
                    gy = offset_from(ry, span);
                end
            endcase
            send_request(rx, ry, yaw, gx, gy);
        end
        req.valid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        if (outstanding != 0)
            $error("%0d responses never arrived", outstanding);
        $display("%0d requests sent (%0d directed, %0d with the goal on the robot), %0d responses checked",
                 sent, directed, on_robot, checked);
        $display("distance exact, turn within 2 lsb; axes, +/-pi turns and wide headings included");
        if (fail_count == 0 && outstanding == 0)
            $display("heading_error_and_distance_tb OK");
        else
            $display("heading_error_and_distance_tb NOT OK");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/hed_pkg.sv
rtl/core/hed_req_if.sv
rtl/core/hed_rsp_if.sv
rtl/core/hed_ctrl.sv
rtl/core/hed_front.sv
rtl/core/hed_sqrt.sv
rtl/core/hed_angle.sv
rtl/core/heading_error_and_distance.sv
test/heading_error_and_distance_check.sv
test/heading_error_and_distance_tb.sv
